FILE: sv/lpfr_pkg.sv
// ----------------------------------------------------------------------------
// lpfr_pkg
// Types and constants shared by the length-prefixed frame receiver.
// ----------------------------------------------------------------------------
package lpfr_pkg;

  localparam int BYTE_W        = 8;
  localparam int HDR_W         = 32;   // width of the little-endian length field
  localparam int HDR_BYTES     = 4;    // header bytes before the payload
  localparam int FRAME_OVERHEAD = 6;   // header plus checksum trailer
  localparam int SUM_W         = 16;
  localparam int KIND_W        = 2;
  localparam int OFFSET_W      = 24;
  localparam int PLEN_W        = 25;
  localparam int DEF_ADDR_BITS = 24;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_CK_LO   = 2'd2,
    PH_CK_HI   = 2'd3
  } phase_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_GOOD     = 2'd1,
    KIND_CK_FAIL  = 2'd2,
    KIND_BAD_LEN  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t                 kind;
    logic [BYTE_W-1:0]     data_byte;
    logic [OFFSET_W-1:0]   offset;
    logic [PLEN_W-1:0]     payload_length;
    logic                  frame_end;
  } res_t;

endpackage

FILE: sv/length_prefixed_frame_receiver_unit.sv
// ----------------------------------------------------------------------------
// length_prefixed_frame_receiver_unit
// Deframes a length-prefixed download frame with a 16-bit additive checksum.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake             Payload
//   in_      input      in_valid / in_ready   in_rx_byte
//   out_     output     out_valid / out_ready out_kind, out_data_byte,
//                                             out_offset, out_payload_length,
//                                             out_frame_end
//
// Every accepted byte is processed in the cycle it is accepted, so the block
// takes one item per clock while in_ready is high. A result is registered
// into the output register, or into a second result register behind it that
// absorbs one result while the output is stalled, so the input only
// stalls once both are full. Reset (rst_n low, synchronous) returns the block
// to the header phase with empty result registers.
//
module length_prefixed_frame_receiver_unit
  import lpfr_pkg::*;
#(
  parameter int ADDR_BITS = DEF_ADDR_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [BYTE_W-1:0]     in_rx_byte,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [KIND_W-1:0]     out_kind,
  output logic [BYTE_W-1:0]     out_data_byte,
  output logic [OFFSET_W-1:0]   out_offset,
  output logic [PLEN_W-1:0]     out_payload_length,
  output logic                  out_frame_end
);

  // The payload count can reach 2**ADDR_BITS itself, so it needs one more bit.
  localparam int CNT_W = ADDR_BITS + 1;
  // Largest payload that still fits the address range.
  localparam logic [HDR_W:0] LIMIT = (HDR_W+1)'(1) << ADDR_BITS;

  // Frame state.
  phase_t              phase_r, phase_nxt;
  logic [HDR_W-1:0]    hdr_r, hdr_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [CNT_W-1:0]    pt_r, pt_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [BYTE_W-1:0]   ck_lo_r, ck_lo_nxt;

  // Result registers: the output stage and the skid stage behind it.
  res_t                out_r, skid_r;
  logic                out_valid_r, skid_valid_r;

  res_t                res;
  logic                res_valid;

  logic                in_fire;
  logic                load_out;
  logic [HDR_W-1:0]    hdr_shift;
  logic [HDR_W:0]      len_m6;
  logic                len_bad;
  logic                hdr_last;
  logic [CNT_W-1:0]    cnt_inc;
  logic [SUM_W-1:0]    ck_word;

  assign in_ready = !skid_valid_r;
  assign in_fire  = in_valid && in_ready;
  assign load_out = !out_valid_r || out_ready;

  // Length bytes arrive least significant first, so they shift in from the top.
  assign hdr_shift = {in_rx_byte, hdr_r[HDR_W-1:BYTE_W]};
  assign len_m6    = {1'b0, hdr_shift} - (HDR_W+1)'(FRAME_OVERHEAD);
  assign len_bad   = (hdr_shift < HDR_W'(FRAME_OVERHEAD)) || (len_m6 > LIMIT);
  assign hdr_last  = (cnt_r == CNT_W'(HDR_BYTES - 1));
  assign cnt_inc   = cnt_r + CNT_W'(1);
  assign ck_word   = {in_rx_byte, ck_lo_r};

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    if (in_fire) begin
      unique case (phase_r)
        PH_HEADER: begin
          if (hdr_last) begin
            if (len_bad) begin
              phase_nxt = PH_HEADER;
            end else if (len_m6 == '0) begin
              phase_nxt = PH_CK_LO;
            end else begin
              phase_nxt = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          if (cnt_inc >= pt_r) begin
            phase_nxt = PH_CK_LO;
          end
        end
        PH_CK_LO: phase_nxt = PH_CK_HI;
        PH_CK_HI: phase_nxt = PH_HEADER;
        default:  phase_nxt = PH_HEADER;
      endcase
    end
  end

  // Datapath updates and the result of the accepted byte.
  always_comb begin
    hdr_nxt   = hdr_r;
    cnt_nxt   = cnt_r;
    pt_nxt    = pt_r;
    sum_nxt   = sum_r;
    ck_lo_nxt = ck_lo_r;
    res       = '0;
    res_valid = 1'b0;
    if (in_fire) begin
      unique case (phase_r)
        PH_HEADER: begin
          hdr_nxt = hdr_shift;
          cnt_nxt = cnt_inc;
          if (hdr_last) begin
            hdr_nxt = '0;
            cnt_nxt = '0;
            sum_nxt = '0;
            if (len_bad) begin
              pt_nxt        = '0;
              res.kind      = KIND_BAD_LEN;
              res.frame_end = 1'b1;
              res_valid     = 1'b1;
            end else begin
              pt_nxt = CNT_W'(len_m6);
            end
          end
        end
        PH_PAYLOAD: begin
          res.kind      = KIND_PAYLOAD;
          res.data_byte = in_rx_byte;
          res.offset    = OFFSET_W'(cnt_r);
          res_valid     = 1'b1;
          sum_nxt       = sum_r + SUM_W'(in_rx_byte);
          cnt_nxt       = cnt_inc;
        end
        PH_CK_LO: begin
          ck_lo_nxt = in_rx_byte;
        end
        PH_CK_HI: begin
          res.kind           = (ck_word == sum_r) ? KIND_GOOD : KIND_CK_FAIL;
          res.payload_length = PLEN_W'(pt_r);
          res.frame_end      = 1'b1;
          res_valid          = 1'b1;
          hdr_nxt            = '0;
          cnt_nxt            = '0;
          sum_nxt            = '0;
          ck_lo_nxt          = '0;
        end
        default: begin
          hdr_nxt = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      hdr_r   <= '0;
      cnt_r   <= '0;
      pt_r    <= '0;
      sum_r   <= '0;
      ck_lo_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      hdr_r   <= hdr_nxt;
      cnt_r   <= cnt_nxt;
      pt_r    <= pt_nxt;
      sum_r   <= sum_nxt;
      ck_lo_r <= ck_lo_nxt;
    end
  end

  // Result registers. The skid stage only fills while the output is stalled,
  // and it always drains into the output stage first to keep results in order.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (load_out) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= res_valid;
      end else begin
        out_valid_r  <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
        if (res_valid) begin
          skid_r <= res;
        end
      end else if (res_valid) begin
        out_r <= res;
      end
    end else if (res_valid) begin
      skid_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = out_r.kind;
  assign out_data_byte      = out_r.data_byte;
  assign out_offset         = out_r.offset;
  assign out_payload_length = out_r.payload_length;
  assign out_frame_end      = out_r.frame_end;

  // The skid stage is never occupied while the output stage is empty.
  assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage holds a result while the output stage is empty");

  // While in the payload phase there is always at least one byte left.
  assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAYLOAD) |-> ((pt_r != '0) && (cnt_r < pt_r)))
    else $error("payload phase entered with no payload bytes left");

  // The checksum high byte always closes the frame.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (phase_r == PH_CK_HI)) |=> (phase_r == PH_HEADER))
    else $error("block did not return to the header phase after the checksum");

  // A payload byte result never closes a frame.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.kind == KIND_PAYLOAD)) |-> !out_r.frame_end)
    else $error("payload byte result marked as frame end");

endmodule
